### rtl/core/esd_pkg.sv
package esd_pkg;

   // Width of the number accumulator; code points carry its low 32 bits.
   localparam int VALUE_WIDTH = 32;

   // Depth of the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef logic [VALUE_WIDTH-1:0] value_type;

   // Input beat: one raw byte of the escaped string.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // Output beat: one decoded code point.
   typedef struct packed {
      logic [31:0] code_point;
      logic        out_last;
   } rsp_type;

   // Queue entry: the one or two results caused by one input byte.
   typedef struct packed {
      rsp_type first;
      logic    has_second;
      rsp_type second;
   } entry_type;

   // Low 32 bits of the accumulator, zero extended when it is narrower.
   function automatic logic [31:0] to_code_point(value_type v);
      logic [63:0] wide;
      wide = 64'(v);
      return wide[31:0];
   endfunction

endpackage

### rtl/core/esd_front.sv
module esd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  esd_pkg::req_type   req_payload,
   input  logic               queue_full,
   output logic               push,
   output esd_pkg::entry_type push_entry
);

   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_ESCAPE = 2'd1;
   localparam logic [1:0] MODE_NUMBER = 2'd2;

   localparam logic [1:0] RADIX_HEX = 2'd0;
   localparam logic [1:0] RADIX_DEC = 2'd1;
   localparam logic [1:0] RADIX_OCT = 2'd2;
   localparam logic [1:0] RADIX_BIN = 2'd3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

   logic [1:0]         mode_ff, mode_in;
   logic [1:0]         radix_ff, radix_in;
   esd_pkg::value_type value_ff, value_in;

   logic               accept;
   logic [7:0]         c;
   logic               last;
   logic               digit_ok;
   logic [3:0]         digit;
   esd_pkg::value_type scaled;
   esd_pkg::value_type value_next;
   logic               norm_emit;
   esd_pkg::rsp_type   norm_rsp;
   logic [1:0]         norm_mode;
   logic [7:0]         ctrl_code;

   assign req_ready = ~queue_full;
   assign accept    = req_valid & req_ready;
   assign c         = req_payload.in_byte;
   assign last      = req_payload.in_last;

   // Digit recognition for the current radix.
   always_comb begin
      digit_ok = 1'b0;
      digit    = 4'd0;
      case (radix_ff)
         RADIX_HEX: begin
            if (c inside {[8'h30:8'h39]}) begin
               digit_ok = 1'b1;
               digit    = 4'(c - 8'h30);
            end else if (c inside {[8'h61:8'h66]}) begin
               digit_ok = 1'b1;
               digit    = 4'(c - 8'h57);
            end else if (c inside {[8'h41:8'h46]}) begin
               digit_ok = 1'b1;
               digit    = 4'(c - 8'h37);
            end
         end
         RADIX_DEC: begin
            digit_ok = c inside {[8'h30:8'h39]};
            digit    = 4'(c - 8'h30);
         end
         RADIX_OCT: begin
            digit_ok = c inside {[8'h30:8'h37]};
            digit    = 4'(c - 8'h30);
         end
         default: begin
            digit_ok = c inside {[8'h30:8'h31]};
            digit    = 4'(c - 8'h30);
         end
      endcase
   end

   // Multiply-add by the constant radix; ten is two shifts and an add.
   always_comb begin
      case (radix_ff)
         RADIX_HEX: scaled = value_ff << 4;
         RADIX_DEC: scaled = (value_ff << 3) + (value_ff << 1);
         RADIX_OCT: scaled = value_ff << 3;
         default:   scaled = value_ff << 1;
      endcase
      value_next = scaled + esd_pkg::VALUE_WIDTH'(digit);
   end

   // Control codes after a backslash; other bytes stand for themselves.
   always_comb begin
      case (c)
         8'h6E:   ctrl_code = 8'd10;  // n
         8'h74:   ctrl_code = 8'd9;   // t
         8'h66:   ctrl_code = 8'd12;  // f
         8'h76:   ctrl_code = 8'd11;  // v
         8'h72:   ctrl_code = 8'd13;  // r
         8'h30:   ctrl_code = 8'd0;   // 0
         8'h62:   ctrl_code = 8'd8;   // b
         8'h61:   ctrl_code = 8'd7;   // a
         default: ctrl_code = c;
      endcase
   end

   // Plain byte handling, shared by normal mode and the end of a number.
   always_comb begin
      norm_rsp.code_point = {24'd0, c};
      norm_rsp.out_last   = last;
      norm_emit           = 1'b1;
      norm_mode           = MODE_NORMAL;
      if (c == CHAR_BACKSLASH) begin
         if (last) begin
            norm_rsp.code_point = 32'd0;
         end else begin
            norm_emit = 1'b0;
            norm_mode = MODE_ESCAPE;
         end
      end
   end

   // Mode sequencing and the results of one byte.
   always_comb begin
      mode_in                = mode_ff;
      radix_in               = radix_ff;
      value_in               = value_ff;
      push                   = 1'b0;
      push_entry.first       = norm_rsp;
      push_entry.has_second  = 1'b0;
      push_entry.second      = norm_rsp;
      case (mode_ff)
         MODE_ESCAPE: begin
            if (c inside {8'h78, 8'h58, 8'h75, 8'h55, 8'h64, 8'h44,
                          8'h6F, 8'h4F, 8'h79, 8'h59}) begin
               if (c inside {8'h64, 8'h44}) begin
                  radix_in = RADIX_DEC;
               end else if (c inside {8'h6F, 8'h4F}) begin
                  radix_in = RADIX_OCT;
               end else if (c inside {8'h79, 8'h59}) begin
                  radix_in = RADIX_BIN;
               end else begin
                  radix_in = RADIX_HEX;
               end
               value_in = '0;
               if (last) begin
                  push                        = 1'b1;
                  push_entry.first.code_point = 32'd0;
                  push_entry.first.out_last   = 1'b1;
                  mode_in                     = MODE_NORMAL;
               end else begin
                  mode_in = MODE_NUMBER;
               end
            end else begin
               push                        = 1'b1;
               push_entry.first.code_point = {24'd0, ctrl_code};
               push_entry.first.out_last   = last;
               mode_in                     = MODE_NORMAL;
            end
         end
         MODE_NUMBER: begin
            if (digit_ok) begin
               value_in = value_next;
               if (last) begin
                  push                        = 1'b1;
                  push_entry.first.code_point = esd_pkg::to_code_point(value_next);
                  push_entry.first.out_last   = 1'b1;
                  mode_in                     = MODE_NORMAL;
               end
            end else begin
               // The number ends; the byte that ended it is decoded as usual.
               push                        = 1'b1;
               push_entry.first.code_point = esd_pkg::to_code_point(value_ff);
               push_entry.first.out_last   = 1'b0;
               push_entry.has_second       = norm_emit;
               mode_in                     = norm_mode;
            end
         end
         default: begin
            push    = norm_emit;
            mode_in = norm_mode;
         end
      endcase
      if (!accept) begin
         push     = 1'b0;
         mode_in  = mode_ff;
         radix_in = radix_ff;
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         radix_ff <= RADIX_HEX;
         value_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         radix_ff <= radix_in;
         value_ff <= value_in;
      end
   end

endmodule

### rtl/core/esd_queue.sv
module esd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  esd_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output esd_pkg::entry_type head_entry
);

   esd_pkg::entry_type                 slots_ff [esd_pkg::QUEUE_DEPTH];
   logic [esd_pkg::QUEUE_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [esd_pkg::QUEUE_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [esd_pkg::QUEUE_AW:0]         count_ff, count_in;

   assign full       = count_ff == (esd_pkg::QUEUE_AW + 1)'(esd_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slots_ff[rd_ptr_ff];

   // Pointer and fill count update; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == esd_pkg::QUEUE_AW'(esd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == esd_pkg::QUEUE_AW'(esd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/esd_back.sv
module esd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  esd_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output esd_pkg::rsp_type   rsp_payload
);

   logic             rsp_valid_ff, rsp_valid_in;
   esd_pkg::rsp_type rsp_payload_ff, rsp_payload_in;
   logic             pend_ff, pend_in;
   esd_pkg::rsp_type pend_rsp_ff, pend_rsp_in;
   logic             load;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // The output register reloads when empty or when its beat is taken.
   // A held second result goes out before the next queue entry.
   always_comb begin
      load           = ~rsp_valid_ff | rsp_ready;
      pop            = load & ~pend_ff & head_valid;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      pend_in        = pend_ff;
      pend_rsp_in    = pend_rsp_ff;
      if (load) begin
         if (pend_ff) begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = pend_rsp_ff;
            pend_in        = 1'b0;
         end else if (head_valid) begin
            rsp_valid_in   = 1'b1;
            rsp_payload_in = head_entry.first;
            pend_in        = head_entry.has_second;
            pend_rsp_in    = head_entry.second;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      pend_rsp_ff    <= pend_rsp_in;
   end

endmodule

### rtl/core/escape_sequence_decoder.sv
// Backslash escape decoder. Bytes of an escaped string enter as req_ beats
// (byte plus last flag); decoded 32-bit code points leave as rsp_ beats,
// the final one of a string marked by out_last. Both channels use valid
// and ready. An escape opening a hex, decimal, octal or binary number
// yields no result until the number ends, so a byte gives zero, one or two
// results.
// A result reaches rsp_ through the queue slot written at the accepting edge
// and then the output register. Throughput: one byte per cycle while each
// byte gives at most one result and the receiver takes every beat. The
// output register sends one code point per cycle while rsp_ready is high,
// so a byte with two results needs an extra output beat; a four-entry queue
// between the decode front and the output stage absorbs those bursts.
// When the receiver stalls, the queue fills and req_ready drops once it is
// full; no beat is lost. Reset returns the decoder to normal mode, empties
// the queue and drops rsp_valid.
module escape_sequence_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  esd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output esd_pkg::rsp_type rsp_payload
);

   logic               queue_full;
   logic               push;
   esd_pkg::entry_type push_entry;
   logic               pop;
   logic               head_valid;
   esd_pkg::entry_type head_entry;

   // Decode front: mode tracking and number accumulation.
   esd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   // Result queue between front and back.
   esd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Output stage: one code point per beat.
   esd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_entry  (head_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### tb/escape_sequence_decoder_tb.sv
module escape_sequence_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Bytes that the decoder treats specially.
   localparam logic [7:0] CHR_BACKSLASH = "\\";
   localparam logic [7:0] CHR_N         = "n";
   localparam logic [7:0] CHR_T         = "t";
   localparam logic [7:0] CHR_F         = "f";
   localparam logic [7:0] CHR_V         = "v";
   localparam logic [7:0] CHR_R         = "r";
   localparam logic [7:0] CHR_B         = "b";
   localparam logic [7:0] CHR_A         = "a";
   localparam logic [7:0] CHR_Q         = "q";
   localparam logic [7:0] CHR_Z         = "z";
   localparam logic [7:0] CHR_COMMA     = ",";
   localparam logic [7:0] CHR_ZERO      = "0";
   localparam logic [7:0] CHR_ONE       = "1";
   localparam logic [7:0] CHR_SEVEN     = "7";
   localparam logic [7:0] CHR_NINE      = "9";
   localparam logic [7:0] CHR_LOWER_A   = "a";
   localparam logic [7:0] CHR_LOWER_F   = "f";
   localparam logic [7:0] CHR_UPPER_A   = "A";
   localparam logic [7:0] CHR_UPPER_F   = "F";
   localparam logic [7:0] CHR_X         = "x";
   localparam logic [7:0] CHR_X_UP      = "X";
   localparam logic [7:0] CHR_U         = "u";
   localparam logic [7:0] CHR_U_UP      = "U";
   localparam logic [7:0] CHR_D         = "d";
   localparam logic [7:0] CHR_D_UP      = "D";
   localparam logic [7:0] CHR_O         = "o";
   localparam logic [7:0] CHR_O_UP      = "O";
   localparam logic [7:0] CHR_Y         = "y";
   localparam logic [7:0] CHR_Y_UP      = "Y";

   localparam int RANDOM_BEATS = 1300;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_LIMIT  = 5000;

   typedef enum logic [1:0] {
      MODE_PLAIN,
      MODE_AFTER_SLASH,
      MODE_IN_NUMBER
   } decode_mode_type;

   typedef enum logic [1:0] {
      RADIX_HEX,
      RADIX_DEC,
      RADIX_OCT,
      RADIX_BIN
   } radix_type;

   typedef struct {
      esd_pkg::req_type beat;
      bit               drain_first;
   } string_byte_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   esd_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   esd_pkg::rsp_type rsp_payload;

   escape_sequence_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #10 clock = ~clock;

   string_byte_type  pending_bytes[$];
   esd_pkg::rsp_type expected_points[$];

   // Decoder state as the testbench sees it.
   decode_mode_type    shadow_mode  = MODE_PLAIN;
   radix_type          shadow_radix = RADIX_HEX;
   esd_pkg::value_type shadow_value = '0;

   int  total_beats      = 0;
   int  strings_built    = 0;
   int  beats_sent       = 0;
   int  results_checked  = 0;
   int  double_results   = 0;
   int  fail_count       = 0;
   int  hold_left        = 0;
   bit  hold_done        = 1'b0;
   bit  driver_offer;
   string_byte_type  next_byte;
   esd_pkg::rsp_type oldest_point;

   function automatic int radix_base(radix_type r);
      case (r)
         RADIX_HEX: return 16;
         RADIX_DEC: return 10;
         RADIX_OCT: return 8;
         default:   return 2;
      endcase
   endfunction

   // Digit value of c in radix r, or -1 when c is not a digit of it.
   function automatic int digit_value(logic [7:0] c, radix_type r);
      case (r)
         RADIX_HEX: begin
            if (c >= CHR_ZERO && c <= CHR_NINE) return int'(c - CHR_ZERO);
            if (c >= CHR_LOWER_A && c <= CHR_LOWER_F) return int'(c - CHR_LOWER_A) + 10;
            if (c >= CHR_UPPER_A && c <= CHR_UPPER_F) return int'(c - CHR_UPPER_A) + 10;
            return -1;
         end
         RADIX_DEC: return (c >= CHR_ZERO && c <= CHR_NINE) ? int'(c - CHR_ZERO) : -1;
         RADIX_OCT: return (c >= CHR_ZERO && c <= CHR_SEVEN) ? int'(c - CHR_ZERO) : -1;
         default:   return (c >= CHR_ZERO && c <= CHR_ONE) ? int'(c - CHR_ZERO) : -1;
      endcase
   endfunction

   function automatic void push_point(logic [31:0] cp, logic last);
      esd_pkg::rsp_type r;
      r.code_point = cp;
      r.out_last   = last;
      expected_points.push_back(r);
   endfunction

   // Advance the decoder state by one byte and queue the code points it yields.
   function automatic void predict_code_points(esd_pkg::req_type beat);
      logic [7:0]  c;
      logic        last;
      logic [31:0] cp;
      bit          opens_number;
      int          d;
      c    = beat.in_byte;
      last = beat.in_last;

      if (shadow_mode == MODE_AFTER_SLASH) begin
         opens_number = 1'b1;
         case (c)
            CHR_X, CHR_X_UP, CHR_U, CHR_U_UP: shadow_radix = RADIX_HEX;
            CHR_D, CHR_D_UP:                  shadow_radix = RADIX_DEC;
            CHR_O, CHR_O_UP:                  shadow_radix = RADIX_OCT;
            CHR_Y, CHR_Y_UP:                  shadow_radix = RADIX_BIN;
            default:                          opens_number = 1'b0;
         endcase
         if (opens_number) begin
            shadow_value = '0;
            if (last) begin
               push_point(32'd0, 1'b1);
               shadow_mode = MODE_PLAIN;
            end else begin
               shadow_mode = MODE_IN_NUMBER;
            end
            return;
         end
         // Control letters map to their ASCII control codes.
         case (c)
            CHR_N:    cp = 32'd10;
            CHR_T:    cp = 32'd9;
            CHR_F:    cp = 32'd12;
            CHR_V:    cp = 32'd11;
            CHR_R:    cp = 32'd13;
            CHR_ZERO: cp = 32'd0;
            CHR_B:    cp = 32'd8;
            CHR_A:    cp = 32'd7;
            default:  cp = {24'd0, c};
         endcase
         push_point(cp, last);
         shadow_mode = MODE_PLAIN;
         return;
      end

      if (shadow_mode == MODE_IN_NUMBER) begin
         d = digit_value(c, shadow_radix);
         if (d >= 0) begin
            shadow_value = shadow_value * esd_pkg::value_type'(radix_base(shadow_radix))
                           + esd_pkg::value_type'(d);
            if (last) begin
               push_point(32'(shadow_value), 1'b1);
               shadow_mode = MODE_PLAIN;
            end
            return;
         end
         // A non-digit ends the number and is then decoded as a plain byte.
         push_point(32'(shadow_value), 1'b0);
         double_results++;
      end

      if (c == CHR_BACKSLASH) begin
         if (last) begin
            push_point(32'd0, 1'b1);
            shadow_mode = MODE_PLAIN;
         end else begin
            shadow_mode = MODE_AFTER_SLASH;
         end
      end else begin
         push_point({24'd0, c}, last);
         shadow_mode = MODE_PLAIN;
      end
   endfunction

   function automatic void add_byte(logic [7:0] c, logic last, bit drain_first);
      string_byte_type b;
      b.beat.in_byte = c;
      b.beat.in_last = last;
      b.drain_first  = drain_first;
      pending_bytes.push_back(b);
   endfunction

   function automatic logic [7:0] control_letter(int i);
      case (i)
         0:       return CHR_N;
         1:       return CHR_T;
         2:       return CHR_F;
         3:       return CHR_V;
         4:       return CHR_R;
         5:       return CHR_ZERO;
         6:       return CHR_B;
         default: return CHR_A;
      endcase
   endfunction

   function automatic logic [7:0] opener_letter(int i);
      case (i)
         0:       return CHR_X;
         1:       return CHR_X_UP;
         2:       return CHR_U;
         3:       return CHR_U_UP;
         4:       return CHR_D;
         5:       return CHR_D_UP;
         6:       return CHR_O;
         7:       return CHR_O_UP;
         8:       return CHR_Y;
         default: return CHR_Y_UP;
      endcase
   endfunction

   function automatic logic [7:0] digit_char(int v, bit upper);
      if (v < 10) return CHR_ZERO + 8'(v);
      return (upper ? CHR_UPPER_A : CHR_LOWER_A) + 8'(v - 10);
   endfunction

   // One random string built from plain bytes, escapes and numbers. A few
   // pieces are noise: stray backslashes and last flags in odd places.
   function automatic void add_random_string(bit drain_first);
      int         pieces;
      int         kind;
      int         ndig;
      int         sel;
      bit         fin;
      bit         first;
      radix_type  r;
      logic [7:0] c;
      pieces = $urandom_range(6, 1);
      first  = drain_first;
      for (int p = 0; p < pieces; p++) begin
         fin  = (p == pieces - 1);
         kind = $urandom_range(99);
         if (kind < 25) begin
            c = 8'($urandom_range(255));
            add_byte(c, fin || ($urandom_range(99) < 3), first);
         end else if (kind < 45) begin
            add_byte(CHR_BACKSLASH, 1'b0, first);
            add_byte(control_letter($urandom_range(7)), fin, 1'b0);
         end else if (kind < 55) begin
            add_byte(CHR_BACKSLASH, 1'b0, first);
            add_byte(8'($urandom_range(255)), fin, 1'b0);
         end else if (kind < 92) begin
            sel = $urandom_range(9);
            r   = (sel < 4) ? RADIX_HEX : (sel < 6) ? RADIX_DEC :
                  (sel < 8) ? RADIX_OCT : RADIX_BIN;
            // Mostly short numbers; some long enough to wrap the accumulator.
            ndig = ($urandom_range(99) < 10) ? $urandom_range(40, 9) : $urandom_range(4);
            add_byte(CHR_BACKSLASH, 1'b0, first);
            add_byte(opener_letter(sel), fin && (ndig == 0), 1'b0);
            for (int i = 0; i < ndig; i++) begin
               add_byte(digit_char($urandom_range(radix_base(r) - 1), $urandom_range(1)),
                        (fin && i == ndig - 1) || ($urandom_range(99) < 2), 1'b0);
            end
         end else begin
            add_byte(CHR_BACKSLASH, fin, first);
         end
         first = 1'b0;
      end
      strings_built++;
   endfunction

   // Driver: offers the pending bytes, predicting results as each beat is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         driver_offer = req_valid;
         if (req_valid && req_ready) begin
            predict_code_points(req_payload);
            beats_sent++;
            driver_offer = 1'b0;
         end
         if (!driver_offer && pending_bytes.size() > 0) begin
            if (pending_bytes[0].drain_first && expected_points.size() != 0) begin
               driver_offer = 1'b0;
            end else if (!(beats_sent >= 700 && beats_sent < 900)
                         && $urandom_range(99) < 38) begin
               driver_offer = 1'b0;
            end else begin
               next_byte    = pending_bytes.pop_front();
               req_payload  <= next_byte.beat;
               driver_offer = 1'b1;
            end
         end
         req_valid <= driver_offer;
      end
   end

   // Monitor: checks each code point beat against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_points.size() == 0) begin
               $error("unexpected code point beat: code_point %h out_last %b",
                      rsp_payload.code_point, rsp_payload.out_last);
               fail_count++;
            end else begin
               oldest_point = expected_points.pop_front();
               if (rsp_payload.code_point !== oldest_point.code_point) begin
                  $error("code_point mismatch: expected %h, actual %h",
                         oldest_point.code_point, rsp_payload.code_point);
                  fail_count++;
               end
               if (rsp_payload.out_last !== oldest_point.out_last) begin
                  $error("out_last mismatch: expected %b, actual %b",
                         oldest_point.out_last, rsp_payload.out_last);
                  fail_count++;
               end
            end
            results_checked++;
         end
         // One long hold-off lets the internal queue fill and stall the input.
         if (!hold_done && results_checked >= 400) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (results_checked >= 650 && results_checked < 900)
                         || ($urandom_range(99) >= 38);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int guard;

      // Plain bytes at both extremes.
      add_byte(8'h00, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b1, 1'b0);
      // Control escape and an unknown letter after a backslash.
      add_byte(CHR_BACKSLASH, 1'b0, 1'b0);
      add_byte(CHR_N, 1'b0, 1'b0);
      add_byte(CHR_BACKSLASH, 1'b0, 1'b0);
      add_byte(CHR_Q, 1'b1, 1'b0);
      // Hex number ended by a non-digit: two results from the comma.
      add_byte(CHR_BACKSLASH, 1'b0, 1'b0);
      add_byte(CHR_X, 1'b0, 1'b0);
      add_byte(CHR_ONE, 1'b0, 1'b0);
      add_byte(CHR_UPPER_F, 1'b0, 1'b0);
      add_byte(CHR_COMMA, 1'b1, 1'b0);
      // Decimal number ended by a backslash that opens a tab escape.
      add_byte(CHR_BACKSLASH, 1'b0, 1'b0);
      add_byte(CHR_D, 1'b0, 1'b0);
      add_byte(CHR_NINE, 1'b0, 1'b0);
      add_byte(CHR_BACKSLASH, 1'b0, 1'b0);
      add_byte(CHR_T, 1'b1, 1'b0);
      // Trailing backslash alone.
      add_byte(CHR_BACKSLASH, 1'b1, 1'b0);
      // Octal opener on the last byte.
      add_byte(CHR_BACKSLASH, 1'b0, 1'b0);
      add_byte(CHR_O_UP, 1'b1, 1'b0);
      // Binary number whose final digit carries the last flag.
      add_byte(CHR_BACKSLASH, 1'b0, 1'b0);
      add_byte(CHR_Y, 1'b0, 1'b0);
      add_byte(CHR_ONE, 1'b0, 1'b0);
      add_byte(CHR_ZERO, 1'b1, 1'b0);
      // Hex number with no digits ends at a plain letter.
      add_byte(CHR_BACKSLASH, 1'b0, 1'b0);
      add_byte(CHR_U_UP, 1'b0, 1'b0);
      add_byte(CHR_Z, 1'b1, 1'b0);
      strings_built = 8;

      total_beats = pending_bytes.size() + RANDOM_BEATS;
      while (pending_bytes.size() < total_beats) begin
         add_random_string(pending_bytes.size() >= 900 && pending_bytes.size() < 910);
      end
      total_beats = pending_bytes.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (beats_sent < total_beats) @(posedge clock);
      guard = 0;
      while (expected_points.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      if (expected_points.size() != 0) begin
         $error("%0d predicted code points never arrived", expected_points.size());
         fail_count++;
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d strings; checked %0d code point beats.",
               beats_sent, strings_built, results_checked);
      $display("Bytes that closed a number: %0d.", double_results);
      if (fail_count == 0) begin
         $display("PASS escape_sequence_decoder");
      end else begin
         $display("FAIL escape_sequence_decoder");
      end
      $finish;
   end

   // Watchdog: ends the run with a failure if it has not finished.
   initial begin
      #4000000;
      $display("FAIL escape_sequence_decoder");
      $finish;
   end

endmodule

### files.f
rtl/core/esd_pkg.sv
rtl/core/esd_front.sv
rtl/core/esd_queue.sv
rtl/core/esd_back.sv
rtl/core/escape_sequence_decoder.sv
tb/escape_sequence_decoder_tb.sv
